@@ design/bmsirq_pkg.sv @@
// Package for the bank mapper with scanline interrupt: item, result and state types,
// register decode codes, reset values and the program bank wrap table.
// No dependencies; every design file imports it.
package bmsirq_pkg;

  // Number of 8K program banks on the cartridge, 2 to 256.
  localparam int PRG_BANKS = 64;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CPU_XLT = 2'd2,
    ACT_PPU_XLT = 2'd3
  } action_t;

  // Register decode: {address[15:13], address[0]} once address[15] is set.
  localparam logic [3:0] REG_BANK_CTRL  = 4'b1000;
  localparam logic [3:0] REG_BANK_DATA  = 4'b1001;
  localparam logic [3:0] REG_MIRROR     = 4'b1010;
  localparam logic [3:0] REG_SRAM_MODE  = 4'b1011;
  localparam logic [3:0] REG_IRQ_COUNT  = 4'b1100;
  localparam logic [3:0] REG_IRQ_LATCH  = 4'b1101;
  localparam logic [3:0] REG_IRQ_OFF    = 4'b1110;
  localparam logic [3:0] REG_IRQ_ON     = 4'b1111;

  // Bank selector codes in the low nibble of the bank control byte.
  localparam logic [3:0] BSEL_CHR0      = 4'h0;
  localparam logic [3:0] BSEL_CHR2      = 4'h1;
  localparam logic [3:0] BSEL_CHR4      = 4'h2;
  localparam logic [3:0] BSEL_CHR7      = 4'h5;
  localparam logic [3:0] BSEL_PRG0      = 4'h6;
  localparam logic [3:0] BSEL_PRG3      = 4'h9;
  localparam logic [3:0] BSEL_CHR1      = 4'hA;
  localparam logic [3:0] BSEL_CHR3      = 4'hB;

  localparam logic [7:0] SRAM_MODE_MASK  = 8'hF4;
  localparam logic [7:0] SRAM_MODE_MATCH = 8'hE4;
  localparam logic [2:0] SRAM_PAGE_NONE  = 3'd4;
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [7:0] CHR_RAM_LAST    = 8'd7;

  typedef struct packed {
    action_t     action;
    logic        display_on;
    logic [8:0]  scanline;
    logic [7:0]  data;
    logic [15:0] address;
  } item_t;

  typedef struct packed {
    logic       irq_out;
    logic [1:0] mirror_mode;
    logic [2:0] sram_page;
    logic       chr_is_ram;
    logic [7:0] chr_bank;
    logic [7:0] prg_bank;
  } result_t;

  typedef struct packed {
    logic [7:0]      bank_control;
    logic [7:0][7:0] chr_slots;
    logic [3:0][7:0] prg_slots;
    logic [1:0]      mirror_select;
    logic [7:0]      sram_mode;
    logic [7:0]      irq_count;
    logic [7:0]      irq_reload;
    logic            irq_enabled;
    logic            irq_pending;
    logic            irq_line;
  } mapper_state_t;

  typedef logic [255:0][7:0] prg_lut_t;

  // Bank number reduced modulo the bank count, for every 8-bit slot value.
  function automatic prg_lut_t prg_lut_build();
    prg_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 8'(i % PRG_BANKS);
    end
    return lut;
  endfunction

  localparam prg_lut_t PRG_LUT = prg_lut_build();

  function automatic mapper_state_t state_reset_value();
    mapper_state_t s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s.chr_slots[i] = 8'(i);
    end
    s.prg_slots[0] = 8'd0;
    s.prg_slots[1] = 8'd1;
    s.prg_slots[2] = 8'(PRG_BANKS - 2);
    s.prg_slots[3] = 8'(PRG_BANKS - 1);
    return s;
  endfunction

  localparam mapper_state_t STATE_RESET = state_reset_value();

endpackage

@@ design/bmsirq_step.sv @@
// Combinational step of the mapper: applies one item to the mapper state and forms
// the result word from the updated state. Depends on bmsirq_pkg.
module bmsirq_step
  import bmsirq_pkg::*;
(
  input  mapper_state_t st,
  input  item_t         item,
  output mapper_state_t st_next,
  output result_t       res
);

  logic [3:0] reg_code;
  logic [3:0] bank_sel;
  logic [7:0] cnt;
  logic [1:0] prg_slot;
  logic [2:0] chr_slot;
  logic [7:0] chr_val;

  assign reg_code = {item.address[15:13], item.address[0]};
  assign bank_sel = st.bank_control[3:0];

  // State update.
  always_comb begin
    st_next = st;
    cnt     = st.irq_count;
    unique case (item.action)
      ACT_WRITE: begin
        if (item.address[15]) begin
          unique case (reg_code)
            REG_BANK_CTRL: st_next.bank_control = item.data;
            REG_BANK_DATA: begin
              case (bank_sel) inside
                BSEL_CHR0: st_next.chr_slots[0] = item.data;
                BSEL_CHR2: st_next.chr_slots[2] = item.data;
                [BSEL_CHR4:BSEL_CHR7]:
                  st_next.chr_slots[3'(bank_sel - BSEL_CHR4) + 3'd4] = item.data;
                [BSEL_PRG0:BSEL_PRG3]:
                  st_next.prg_slots[2'(bank_sel - BSEL_PRG0)] = item.data;
                BSEL_CHR1: st_next.chr_slots[1] = item.data;
                BSEL_CHR3: st_next.chr_slots[3] = item.data;
                default: ;
              endcase
            end
            REG_MIRROR:    st_next.mirror_select = item.data[1:0];
            REG_SRAM_MODE: st_next.sram_mode = item.data;
            REG_IRQ_COUNT: begin
              st_next.irq_count   = item.data;
              st_next.irq_pending = 1'b0;
            end
            REG_IRQ_LATCH: begin
              st_next.irq_reload  = item.data;
              st_next.irq_pending = 1'b0;
            end
            REG_IRQ_OFF: begin
              st_next.irq_enabled = 1'b0;
              st_next.irq_pending = 1'b0;
              st_next.irq_line    = 1'b0;
            end
            REG_IRQ_ON: begin
              st_next.irq_enabled = 1'b1;
              st_next.irq_pending = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ACT_TICK: begin
        if (item.scanline <= LAST_VISIBLE_LINE && item.display_on &&
            st.irq_enabled && !st.irq_pending) begin
          // Line zero takes one extra count off a running counter.
          if (item.scanline == '0 && cnt != '0) begin
            cnt = cnt - 8'd1;
          end
          if (cnt == '0) begin
            st_next.irq_pending = 1'b1;
            st_next.irq_line    = 1'b1;
            cnt = st.irq_reload;
          end
          st_next.irq_count = cnt - 8'd1;
        end
      end
      default: ;
    endcase
  end

  // Address translation reads the state, which translate items never change.
  always_comb begin
    prg_slot = item.address[14:13];
    if (!prg_slot[0]) begin
      prg_slot[1] = prg_slot[1] ^ st.bank_control[6];
    end
    chr_slot = item.address[12:10] ^ {st.bank_control[7], 2'b00};
    chr_val  = st.chr_slots[chr_slot];

    res             = '0;
    res.sram_page   = SRAM_PAGE_NONE;
    res.mirror_mode = st_next.mirror_select;
    res.irq_out     = st_next.irq_line;
    if (item.action == ACT_CPU_XLT) begin
      if (item.address[15]) begin
        res.prg_bank = PRG_LUT[st.prg_slots[prg_slot]];
      end else if (item.address[14:13] == 2'b11) begin
        if ((st.sram_mode & SRAM_MODE_MASK) == SRAM_MODE_MATCH) begin
          res.sram_page = {1'b0, st.sram_mode[1:0]};
        end
      end
    end else if (item.action == ACT_PPU_XLT) begin
      if (item.address[15:13] == 3'b000) begin
        res.chr_bank   = chr_val;
        res.chr_is_ram = (chr_val <= CHR_RAM_LAST);
      end
    end
  end

endmodule

@@ design/bank_mapper_with_scanline_irq.sv @@
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Holds the input register, the mapper state and the result register; the step
// logic lives in bmsirq_step. Depends on bmsirq_pkg.
//
// Use: every word on the slave stream is one access: a register write, a
// scanline tick, a CPU address translate or a PPU address translate, chosen by
// s_axis_tuser. Every accepted word gives exactly one result word on the master
// stream, in order. The result carries the program and pattern banks for a
// translate (zero otherwise), the work RAM page (4 for normal or unused), and
// the current mirroring and interrupt line as they stand after the access.
//
// Flow: a word accepted into the input register is applied to the mapper state
// by short logic when it moves on, and its result is held in the result register
// and presented on m_axis. The block sustains one word per clock while the receiver
// takes results; the only loop is the state register feeding the step logic.
//
// Reset (rst, synchronous, active high) empties both registers and loads the
// power-up bank layout: pattern slots 0..7, program slots 0, 1 and the last two
// banks, everything else zero. When the receiver stalls, the result register holds
// its word; the input register still takes a word if it is empty, and only then
// does s_axis_tready drop until the result is taken.
module bank_mapper_with_scanline_irq
  import bmsirq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, low bit up: address[15:0], data[23:16], scanline[32:24], display_on[33], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: action[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, low bit up: prg_bank[7:0], chr_bank[15:8], chr_is_ram[16], sram_page[19:17],
  // mirror_mode[21:20], irq_out[22], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  item_t         in_item;
  item_t         s1_item;
  logic          s1_valid;
  logic          advance;
  mapper_state_t st;
  mapper_state_t st_next;
  result_t       res;
  result_t       out_res;
  logic          out_valid;

  assign in_item.action     = action_t'(s_axis_tuser);
  assign in_item.address    = s_axis_tdata[15:0];
  assign in_item.data       = s_axis_tdata[23:16];
  assign in_item.scanline   = s_axis_tdata[32:24];
  assign in_item.display_on = s_axis_tdata[33];

  // The held word moves on when the result register is empty or being drained.
  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  bmsirq_step u_step (
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_res};

`ifndef SYNTHESIS
  // The interrupt line is only raised while enabled, and disabling drops it.
  a_line_needs_enable: assert property (@(posedge clk) disable iff (rst)
    st.irq_line |-> st.irq_enabled)
    else $error("irq line high while irq disabled");

  // A pending interrupt always has its line raised.
  a_pending_has_line: assert property (@(posedge clk) disable iff (rst)
    st.irq_pending |-> st.irq_line)
    else $error("irq pending without irq line");

  // The mapper state changes only when a word is applied.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("mapper state changed without an applied word");

  // Program banks are always reduced below the bank count.
  a_prg_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_res.prg_bank} < 9'(PRG_BANKS)))
    else $error("program bank out of range");

  // Work RAM page is a page number or the normal-bank code.
  a_page_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.sram_page <= SRAM_PAGE_NONE))
    else $error("work RAM page out of range");
`endif

endmodule
